/* rtl/ile_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg: shared definitions of the indexed list engine
// Opcodes, status codes, cell shift modes and default sizes.
// ----------------------------------------------------------------------------
package ile_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 64;
	localparam int VALUE_BITS_DEF = 32;

	// fixed field widths of the ports
	localparam int OPCODE_W   = 3;
	localparam int POSITION_W = 12;
	localparam int ITEM_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 11;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP    = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_AT     = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_COUNT  = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_FIND   = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd7;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

	// cell shift modes
	localparam logic [1:0] MODE_HOLD   = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	// broadcast control to every cell of the chain
	typedef struct packed {
		logic [1:0] mode;
		logic       probe;
	} ile_cell_ctl_t;

endpackage

/* rtl/ile_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_cell: one storage cell of the list chain
// Holds one entry, takes a neighbor's value on insert or delete shifts and
// registers its match and read-out leaf for the reduction tree.
// ----------------------------------------------------------------------------
module ile_cell #(
	parameter int POS        = 0,
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32,
	localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW        = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  ile_pkg::ile_cell_ctl_t  ctl,
	input  logic [IW-1:0]           target,
	input  logic [IW-1:0]           pick,
	input  logic [LW-1:0]           length,
	input  logic [VALUE_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0]   left_val,
	input  logic [VALUE_BITS-1:0]   right_val,
	output logic [VALUE_BITS-1:0]   value,
	output logic                    leaf_hit,
	output logic [VALUE_BITS-1:0]   leaf_val
);
	import ile_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(POS);
	localparam logic [LW-1:0] MY_LEN = LW'(POS);

	logic [VALUE_BITS-1:0] value_q;
	logic                  hit_s1;
	logic [VALUE_BITS-1:0] pick_s1;

	// entry storage with neighbor shifts
	always_ff @(posedge clk) begin
		case (ctl.mode)
			MODE_INSERT: begin
				if (MY_IDX > target) begin
					value_q <= left_val;
				end else if (MY_IDX == target) begin
					value_q <= key;
				end
			end
			MODE_DELETE: begin
				if (MY_IDX >= target) begin
					value_q <= right_val;
				end
			end
			default: begin
			end
		endcase
	end

	// leaves for the count, search and read-out tree
	always_ff @(posedge clk) begin
		if (ctl.probe) begin
			hit_s1  <= (value_q == key) && (MY_LEN < length);
			pick_s1 <= (MY_IDX == pick) ? value_q : '0;
		end
	end

	assign value    = value_q;
	assign leaf_hit = hit_s1;
	assign leaf_val = pick_s1;

endmodule

/* rtl/ile_tree.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_tree: registered reduction tree over the cell leaves
// Gives any-match, first matching index, match count and the picked value,
// one register level per tree level.
// ----------------------------------------------------------------------------
module ile_tree #(
	parameter int DEPTH      = 64,
	parameter int VALUE_BITS = 32,
	localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW        = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  leaf_hit [DEPTH],
	input  logic [VALUE_BITS-1:0] leaf_val [DEPTH],
	output logic                  root_hit,
	output logic [IW-1:0]         root_first,
	output logic [LW-1:0]         root_count,
	output logic [VALUE_BITS-1:0] root_val
);
	import ile_pkg::*;

	localparam int LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 0;
	localparam int NLEAF  = 1 << LEVELS;
	localparam int NODES  = 2 * NLEAF - 1;

	// heap order: node k has children 2k+1 and 2k+2
	logic                  node_hit_q   [NODES];
	logic [IW-1:0]         node_first_q [NODES];
	logic [LW-1:0]         node_count_q [NODES];
	logic [VALUE_BITS-1:0] node_val_q   [NODES];

	for (genvar k = 0; k < NODES; k++) begin : g_node
		if (k >= NLEAF - 1) begin : g_leaf
			localparam int LI = k - (NLEAF - 1);
			if (LI < DEPTH) begin : g_used
				assign node_hit_q[k]   = leaf_hit[LI];
				assign node_first_q[k] = IW'(LI);
				assign node_count_q[k] = LW'(leaf_hit[LI]);
				assign node_val_q[k]   = leaf_val[LI];
			end else begin : g_pad
				assign node_hit_q[k]   = 1'b0;
				assign node_first_q[k] = '0;
				assign node_count_q[k] = '0;
				assign node_val_q[k]   = '0;
			end
		end else begin : g_inner
			// combine left and right subtrees, left wins the first index
			always_ff @(posedge clk) begin
				node_hit_q[k]   <= node_hit_q[2*k+1] | node_hit_q[2*k+2];
				node_first_q[k] <= node_hit_q[2*k+1] ? node_first_q[2*k+1]
				                                      : node_first_q[2*k+2];
				node_count_q[k] <= node_count_q[2*k+1] + node_count_q[2*k+2];
				node_val_q[k]   <= node_val_q[2*k+1] | node_val_q[2*k+2];
			end
		end
	end

	assign root_hit   = node_hit_q[0];
	assign root_first = node_first_q[0];
	assign root_count = node_count_q[0];
	assign root_val   = node_val_q[0];

endmodule

/* rtl/indexed_list_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_top: ordered list of values with indexed operations
// A chain of cells holds the list; a registered tree counts and searches it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries opcode, position and
//   item_value; output channel (out_valid / out_stall) returns status,
//   read_value, count_or_place and list_length, one result per operation.
//   One operation is in flight at a time. A transfer on the input is
//   followed by the compare in the cells and the registered tree
//   reduction before the result is loaded into the output register;
//   the next input transfer can happen in the cycle after that. The
//   depth of the registered reduction tree over the cells sets how long
//   the block waits. Shifts for insert, remove and pop move the entries
//   after the target position by one place, and insert writes the new
//   value at the target, when the result is loaded into the output register.
//   Reset clears the length to zero; cell contents stay undefined and are
//   never read before they are written.
//   While out_stall holds a finished result, it waits unchanged in the output
//   register; a next operation may be accepted, then keeps in_stall high until it can load.
// ----------------------------------------------------------------------------
module indexed_list_engine_top #(
	parameter int DEPTH      = ile_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = ile_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ile_pkg::OPCODE_W-1:0]      opcode,
	input  logic signed [ile_pkg::POSITION_W-1:0] position,
	input  logic [ile_pkg::ITEM_W-1:0]        item_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ile_pkg::STATUS_W-1:0]      status,
	output logic [ile_pkg::ITEM_W-1:0]        read_value,
	output logic [ile_pkg::COUNT_W-1:0]       count_or_place,
	output logic [ile_pkg::COUNT_W-1:0]       list_length
);
	import ile_pkg::*;

	localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW     = $clog2(DEPTH + 1);
	localparam int LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 0;
	localparam int RB     = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;
	localparam int WW     = $clog2(LEVELS + 2);
	localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);
	localparam logic [WW-1:0] WAIT_INIT = WW'(LEVELS + 1);

	// controller states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WAIT = 1'b1;

	logic                  state_q;
	logic [WW-1:0]         wait_q;
	logic [LW-1:0]         length_q;
	logic [OPCODE_W-1:0]   op_q;
	logic signed [POSITION_W-1:0] pos_q;
	logic [VALUE_BITS-1:0] key_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [ITEM_W-1:0]     read_value_q;
	logic [COUNT_W-1:0]    place_q;
	logic [COUNT_W-1:0]    list_length_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  do_update;

	logic signed [12:0]    pos_x;
	logic signed [12:0]    len_x;
	logic signed [12:0]    ins_raw;
	logic signed [12:0]    ins_cl;
	logic signed [12:0]    pa_raw;
	logic                  pa_ok;
	logic [IW-1:0]         ins_idx;
	logic [IW-1:0]         pa_idx;
	logic                  is_full;

	logic                  root_hit;
	logic [IW-1:0]         root_first;
	logic [LW-1:0]         root_count;
	logic [VALUE_BITS-1:0] root_val;

	ile_cell_ctl_t         cell_ctl;
	logic [IW-1:0]         cell_target;
	logic [1:0]            upd_mode;
	logic [STATUS_W-1:0]   upd_status;
	logic [ITEM_W-1:0]     upd_read;
	logic [COUNT_W-1:0]    upd_place;
	logic [LW-1:0]         upd_length;

	logic [VALUE_BITS-1:0] cell_val  [DEPTH];
	logic                  leaf_hit  [DEPTH];
	logic [VALUE_BITS-1:0] leaf_val  [DEPTH];

	// handshake
	assign in_stall  = (state_q == ST_WAIT);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign do_update = (state_q == ST_WAIT) && (wait_q == '0) && out_free;

	// index arithmetic for insert, pop and at
	always_comb begin
		pos_x   = 13'(pos_q);
		len_x   = signed'(13'(length_q));
		ins_raw = (pos_x < 0) ? pos_x + len_x + 13'sd1 : pos_x;
		if (ins_raw < 0) begin
			ins_cl = '0;
		end else if (ins_raw > len_x) begin
			ins_cl = len_x;
		end else begin
			ins_cl = ins_raw;
		end
		pa_raw  = (pos_x < 0) ? pos_x + len_x : pos_x;
		pa_ok   = (pa_raw >= 0) && (pa_raw < len_x);
		ins_idx = (op_q == OP_APPEND) ? length_q[IW-1:0] : ins_cl[IW-1:0];
		pa_idx  = pa_raw[IW-1:0];
		is_full = (length_q == FULL_LEN);
	end

	// operation outcome once the tree root is valid
	always_comb begin
		upd_mode    = MODE_HOLD;
		upd_status  = ST_OK;
		upd_read    = '0;
		upd_place   = '0;
		upd_length  = length_q;
		cell_target = pa_idx;
		case (op_q)
			OP_APPEND, OP_INSERT: begin
				cell_target = ins_idx;
				if (is_full) begin
					upd_status = ST_FULL;
				end else begin
					upd_mode   = MODE_INSERT;
					upd_length = length_q + LW'(1);
				end
			end
			OP_REMOVE: begin
				cell_target = root_first;
				if (root_hit) begin
					upd_mode   = MODE_DELETE;
					upd_length = length_q - LW'(1);
				end else begin
					upd_status = ST_MISSING;
				end
			end
			OP_POP, OP_AT: begin
				if (pa_ok) begin
					upd_read = ITEM_W'(root_val[RB-1:0]);
					if (op_q == OP_POP) begin
						upd_mode   = MODE_DELETE;
						upd_length = length_q - LW'(1);
					end
				end else begin
					upd_status = ST_RANGE;
				end
			end
			OP_COUNT: begin
				upd_place = COUNT_W'(root_count);
			end
			OP_FIND: begin
				if (root_hit) begin
					upd_place = COUNT_W'(root_first);
				end else begin
					upd_status = ST_MISSING;
				end
			end
			OP_CLEAR: begin
				upd_length = '0;
			end
			default: begin
			end
		endcase
	end

	assign cell_ctl.mode  = do_update ? upd_mode : MODE_HOLD;
	assign cell_ctl.probe = (state_q == ST_WAIT);

	// sequencer and list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wait_q   <= '0;
			length_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_WAIT;
						wait_q  <= WAIT_INIT;
					end
				end
				ST_WAIT: begin
					if (wait_q != '0) begin
						wait_q <= wait_q - WW'(1);
					end else if (out_free) begin
						state_q  <= ST_IDLE;
						length_q <= upd_length;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operation registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= opcode;
			pos_q <= position;
			key_q <= VALUE_BITS'(item_value[RB-1:0]);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (do_update) begin
			status_q      <= upd_status;
			read_value_q  <= upd_read;
			place_q       <= upd_place;
			list_length_q <= COUNT_W'(upd_length);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign read_value     = read_value_q;
	assign count_or_place = place_q;
	assign list_length    = list_length_q;

	// chain of storage cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_v;
		logic [VALUE_BITS-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = cell_val[i];
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end
		ile_cell #(
			.POS        (i),
			.DEPTH      (DEPTH),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.target    (cell_target),
			.pick      (pa_idx),
			.length    (length_q),
			.key       (key_q),
			.left_val  (left_v),
			.right_val (right_v),
			.value     (cell_val[i]),
			.leaf_hit  (leaf_hit[i]),
			.leaf_val  (leaf_val[i])
		);
	end

	// count, search and read-out reduction
	ile_tree #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_tree (
		.clk        (clk),
		.leaf_hit   (leaf_hit),
		.leaf_val   (leaf_val),
		.root_hit   (root_hit),
		.root_first (root_first),
		.root_count (root_count),
		.root_val   (root_val)
	);

`ifndef NO_ASSERTIONS
	// length never grows past the number of cells
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= FULL_LEN)
		else $error("list length exceeds depth");

	// an input transfer always starts the wait sequence
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_WAIT) && (wait_q == WAIT_INIT))
		else $error("accepted item did not start processing");

	// a full status only on a full list
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(do_update && (upd_status == ST_FULL)) |-> (upd_length == FULL_LEN))
		else $error("full status with free cells");

	// length moves by at most one except on clear
	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_update && (op_q != OP_CLEAR)) |=>
		(length_q == $past(length_q)) || (length_q == $past(length_q) + LW'(1)) ||
		(length_q == $past(length_q) - LW'(1)))
		else $error("length changed by more than one");

	// the idle controller holds no pending wait count
	a_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (wait_q == '0))
		else $error("wait count left over in idle");
`endif

endmodule
